>>> rtl/bayer_dpcm_vlc_decoder_macros.svh
// Assertion macros shared by the Bayer DPCM decoder modules.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef BAYER_DPCM_VLC_DECODER_MACROS_SVH
`define BAYER_DPCM_VLC_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bdv_pkg.sv
// Shared types, constants and code classifier for the Bayer DPCM decoder.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package bdv_pkg;

    // Configuration register indexes and defaults
    localparam int          C_CFG_W            = 11;
    localparam logic        C_REG_FRAME_WIDTH  = 1'b0;
    localparam logic        C_REG_FRAME_HEIGHT = 1'b1;
    localparam logic [10:0] C_RESET_WIDTH      = 11'd352;
    localparam logic [10:0] C_RESET_HEIGHT     = 11'd288;
    localparam logic [10:0] C_MIN_WIDTH        = 11'd4;
    localparam logic [10:0] C_MIN_HEIGHT       = 11'd2;

    // Index of the last pixel in the longest run for one input item (8 pixels)
    localparam logic [2:0]  C_RUN_LAST         = 3'd7;

    // Prefix code masks and patterns
    localparam logic [7:0] C_MASK_1   = 8'h80;
    localparam logic [7:0] C_MASK_3   = 8'hE0;
    localparam logic [7:0] C_PAT_P4   = 8'h80;
    localparam logic [7:0] C_PAT_M4   = 8'hA0;
    localparam logic [7:0] C_MASK_4   = 8'hF0;
    localparam logic [7:0] C_PAT_P11  = 8'hD0;
    localparam logic [7:0] C_PAT_M11  = 8'hF0;
    localparam logic [7:0] C_MASK_5   = 8'hF8;
    localparam logic [7:0] C_PAT_P20  = 8'hC8;
    localparam logic [7:0] C_MASK_6   = 8'hFC;
    localparam logic [7:0] C_PAT_M20  = 8'hC0;
    localparam logic [7:0] C_PAT_UNK  = 8'hC4;
    localparam logic [3:0] C_RAW_LEN  = 4'd8;

    // Classified code
    typedef struct packed {
        logic [3:0]        len;
        logic signed [8:0] delta;
        logic              absolute;
    } t_code;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic will_run;
        logic more;
        logic out_free;
    } t_sts;

    // Decode the prefix code at the top of an 8-bit window
    function automatic t_code f_classify(input logic [7:0] w);
        t_code c;
        c.absolute = 1'b0;
        c.delta    = 9'sd0;
        c.len      = 4'd8;
        if ((w & C_MASK_1) == 8'h00) begin
            c.len = 4'd1;
        end else if ((w & C_MASK_3) == C_PAT_P4) begin
            c.len   = 4'd3;
            c.delta = 9'sd4;
        end else if ((w & C_MASK_3) == C_PAT_M4) begin
            c.len   = 4'd3;
            c.delta = -9'sd4;
        end else if ((w & C_MASK_4) == C_PAT_P11) begin
            c.len   = 4'd4;
            c.delta = 9'sd11;
        end else if ((w & C_MASK_4) == C_PAT_M11) begin
            c.len   = 4'd4;
            c.delta = -9'sd11;
        end else if ((w & C_MASK_5) == C_PAT_P20) begin
            c.len   = 4'd5;
            c.delta = 9'sd20;
        end else if ((w & C_MASK_6) == C_PAT_M20) begin
            c.len   = 4'd6;
            c.delta = -9'sd20;
        end else if ((w & C_MASK_6) == C_PAT_UNK) begin
            c.len   = 4'd8;
        end else begin
            // absolute nibble code
            c.len      = 4'd8;
            c.absolute = 1'b1;
            c.delta    = $signed({1'b0, w[3:0], 4'b0000});
        end
        return c;
    endfunction

endpackage

>>> rtl/bdv_ctrl.sv
// Controller FSM of the Bayer DPCM decoder: byte intake and pixel run sequencing.
// Depends on bdv_pkg and bayer_dpcm_vlc_decoder_macros.svh.
`timescale 1ns / 1ps
`include "bayer_dpcm_vlc_decoder_macros.svh"

module bdv_ctrl
    import bdv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DECODE = 1'b1;

    logic       r_state;
    logic       n_state;
    logic [2:0] r_run_cnt;
    logic [2:0] n_run_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_run_cnt  = r_run_cnt;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_run_cnt  = 3'd0;
                    if (i_sts.will_run) begin
                        n_state = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.last = !i_sts.more || (r_run_cnt == C_RUN_LAST);
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_run_cnt = r_run_cnt + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_run_cnt <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_run_cnt <= n_run_cnt;
        end
    end

    `BDV_ASSERT_NOW(a_no_step_in_idle, r_state == ST_IDLE, !o_cmd.step, "pixel step while idle")
    `BDV_ASSERT_NEXT(a_last_ends_run, o_cmd.step && o_cmd.last, r_state == ST_IDLE, "run did not end")
    `BDV_ASSERT_NOW(a_step_has_room, o_cmd.step, i_sts.out_free, "pixel step with full output")

endmodule

>>> rtl/bdv_datapath.sv
// Datapath of the Bayer DPCM decoder: bit reservoir, code decode, prediction,
// two-line store and output register. Depends on bdv_pkg and the macro header.
`timescale 1ns / 1ps
`include "bayer_dpcm_vlc_decoder_macros.svh"

module bdv_datapath
    import bdv_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [10:0]  i_cfg_data,
    input  logic [7:0]   i_data_byte,
    input  logic         i_frame_start,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [7:0]   o_pixel,
    output logic         o_frame_end,
    output logic         o_last_of_run,
    input  t_cmd         i_cmd,
    output t_sts         o_sts
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = 2 * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration and frame state
    logic [10:0]      r_cfg_width;
    logic [10:0]      r_cfg_height;
    logic [14:0]      r_res;
    logic [14:0]      n_res;
    logic [3:0]       r_cnt;
    logic [3:0]       n_cnt;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic             r_active;
    logic             n_active;
    logic [7:0]       r_left0;
    logic [7:0]       r_left1;

    // Two-line store
    logic [7:0]        mem_line [DEPTH];
    logic [7:0]        r_up;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_pixel;
    logic       r_fend;
    logic       r_last;

    // Decode signals
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;
    logic [7:0]        win;
    logic              is_raw;
    t_code             code;
    logic [3:0]        len;
    logic [8:0]        sum_ul;
    logic [7:0]        pred;
    logic signed [9:0] val;
    logic [7:0]        clamped;
    logic [7:0]        pix;
    logic [3:0]        cnt_c;
    logic [14:0]       res_c;
    logic [WW-1:0]     col_inc;
    logic [HW-1:0]     row_inc;
    logic              row_end;
    logic              fend;
    logic [ROW_W-1:0]  step_row;
    logic [COL_W-1:0]  step_col;
    logic              nx_raw;
    logic [3:0]        nx_need;
    t_code             nx_code;

    // Next 8 bits of the reservoir, zero padded below
    function automatic logic [7:0] f_peek(input logic [14:0] res, input logic [3:0] cnt);
        logic [22:0] t;
        t = {res, 8'h00} >> cnt;
        return t[7:0];
    endfunction

    // Line store slot of a position
    function automatic logic [ADDR_W-1:0] f_slot(input logic odd, input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(col);
        if (odd) begin
            a = ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
        end
        return a;
    endfunction

    // Effective frame size
    always_comb begin
        if (r_cfg_width < C_MIN_WIDTH) begin
            eff_w = WW'(C_MIN_WIDTH);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        if (r_cfg_height < C_MIN_HEIGHT) begin
            eff_h = HW'(C_MIN_HEIGHT);
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_height);
        end
    end

    // Decode of the current pixel
    always_comb begin
        win    = f_peek(r_res, r_cnt);
        is_raw = (32'(r_row) < 32'd2) && (32'(r_col) < 32'd2);
        code   = f_classify(win);
        len    = is_raw ? C_RAW_LEN : code.len;
        sum_ul = {1'b0, r_up} + {1'b0, r_left1};
        if (32'(r_col) < 32'd2) begin
            pred = r_up;
        end else if (32'(r_row) < 32'd2) begin
            pred = r_left1;
        end else begin
            pred = sum_ul[8:1];
        end
        val = $signed({2'b00, pred}) + $signed({code.delta[8], code.delta});
        if (val[9]) begin
            clamped = 8'd0;
        end else if (val[8]) begin
            clamped = 8'd255;
        end else begin
            clamped = val[7:0];
        end
        if (is_raw) begin
            pix = win;
        end else if (code.absolute) begin
            pix = code.delta[7:0];
        end else begin
            pix = clamped;
        end
    end

    // Position advance and lookahead for the next pixel of this item
    always_comb begin
        cnt_c   = r_cnt - len;
        res_c   = r_res & ((15'd1 << cnt_c) - 15'd1);
        col_inc = WW'(r_col) + WW'(1);
        row_inc = HW'(r_row) + HW'(1);
        row_end = (col_inc >= eff_w);
        fend    = row_end && (row_inc >= eff_h);
        step_col = row_end ? '0 : col_inc[COL_W-1:0];
        if (fend) begin
            step_row = '0;
        end else if (row_end) begin
            step_row = row_inc[ROW_W-1:0];
        end else begin
            step_row = r_row;
        end
        nx_raw  = (32'(step_row) < 32'd2) && (32'(step_col) < 32'd2);
        nx_code = f_classify(f_peek(res_c, cnt_c));
        nx_need = nx_raw ? C_RAW_LEN : nx_code.len;
    end

    // Status to the controller
    always_comb begin
        o_sts.will_run = i_frame_start || r_active;
        o_sts.more     = !fend && (nx_need <= cnt_c);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Next frame state
    always_comb begin
        n_res    = r_res;
        n_cnt    = r_cnt;
        n_row    = r_row;
        n_col    = r_col;
        n_active = r_active;
        if (i_cmd.load) begin
            if (i_frame_start) begin
                n_res    = {7'd0, i_data_byte};
                n_cnt    = 4'd8;
                n_row    = '0;
                n_col    = '0;
                n_active = 1'b1;
            end else if (r_active) begin
                n_res = {r_res[6:0], i_data_byte};
                n_cnt = (r_cnt >= 4'd8) ? 4'd15 : r_cnt + 4'd8;
            end
        end else if (i_cmd.step) begin
            n_res    = fend ? 15'd0 : res_c;
            n_cnt    = fend ? 4'd0 : cnt_c;
            n_row    = step_row;
            n_col    = step_col;
            n_active = !fend;
        end
    end

    assign wr_addr = f_slot(r_row[0], r_col);
    assign rd_addr = f_slot(n_row[0], n_col);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= C_RESET_WIDTH;
            r_cfg_height <= C_RESET_HEIGHT;
            r_res        <= 15'd0;
            r_cnt        <= 4'd0;
            r_row        <= '0;
            r_col        <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    C_REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                    C_REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_res    <= n_res;
            r_cnt    <= n_cnt;
            r_row    <= n_row;
            r_col    <= n_col;
            r_active <= n_active;
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: output, left history
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pixel <= pix;
            r_fend  <= fend;
            r_last  <= i_cmd.last;
            r_left1 <= r_left0;
            r_left0 <= pix;
        end
    end

    // Two-line store: write current slot, read slot of the next position
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            mem_line[wr_addr] <= pix;
        end
        r_up <= mem_line[rd_addr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel       = r_pixel;
    assign o_frame_end   = r_fend;
    assign o_last_of_run = r_last;

    `BDV_ASSERT_NOW(a_code_fits, i_cmd.step, len <= r_cnt, "code longer than held bits")
    `BDV_ASSERT_NEXT(a_frame_end_idles, i_cmd.step && fend, !r_active && (r_cnt == 4'd0), "frame end did not stop")
    `BDV_ASSERT_NOW(a_step_when_active, i_cmd.step, r_active, "pixel step outside a frame")

endmodule

>>> rtl/bayer_dpcm_vlc_decoder.sv
// Bayer DPCM prefix-code decoder, top level. An accepted byte is loaded, then one pixel
// is decoded per cycle while the output has room, up to 8 pixels per byte; no new byte
// is accepted until that run ends. The current and lookahead code classifiers and the
// one-read one-write two-line store set the pace of one pixel per cycle.
// Reset (i_rst_n low, synchronous) restores 352x288 and waits for a frame start;
// the line store is not cleared.
`timescale 1ns / 1ps

module bayer_dpcm_vlc_decoder
    import bdv_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pixel,
    output logic        o_frame_end,
    output logic        o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    bdv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Decode datapath
    bdv_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel       (o_pixel),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

>>> tb/sv/bayer_dpcm_vlc_decoder_tb.sv
// Self-checking testbench for the Bayer DPCM prefix-code decoder.
// Drives bytes and register writes; checks pixels against a built-in decoder.
// Depends on bdv_pkg and bayer_dpcm_vlc_decoder.
`timescale 1ns / 1ps

module bayer_dpcm_vlc_decoder_tb;
    import bdv_pkg::*;

    localparam int NUM_KINDS      = 9;
    localparam int LINE_DEPTH     = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_ERR_PRINT  = 40;
    localparam int RANDOM_ITEMS   = 210;

    // Prefix code kinds
    typedef enum int {
        CK_ZERO, CK_PLUS4, CK_MINUS4, CK_PLUS11, CK_MINUS11,
        CK_PLUS20, CK_MINUS20, CK_UNKNOWN, CK_ABS
    } code_kind_e;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_end;
        logic       last_of_run;
    } pix_t;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_op_e;

    typedef struct packed {
        row_op_e     op;
        logic        idx;
        logic [10:0] value;
        logic [7:0]  data;
        logic        fs;
        logic        typed;
        logic [7:0]  exp_pixel;
    } stim_row_t;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [10:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_frame_start;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_pixel;
    logic        o_frame_end;
    logic        o_last_of_run;

    bayer_dpcm_vlc_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel       (o_pixel),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Decoder state mirrored by the testbench
    logic [10:0] reg_width;
    logic [10:0] reg_height;
    int unsigned dec_resv;
    int unsigned dec_nbits;
    int unsigned dec_row;
    int unsigned dec_col;
    logic [7:0]  dec_line [0:2*LINE_DEPTH-1];
    logic [7:0]  dec_hist0;
    logic [7:0]  dec_hist1;
    bit          dec_active;

    pix_t        pixel_q [$];     // pixels still owed by the DUT
    pix_t        decoded_px [$];  // pixels of the byte just decoded
    bit          gen_bits [$];    // pending bits of generated codes
    stim_row_t   dir_rows [$];

    int          err_count;
    int          n_items;
    int          tx_burst_left;
    int          idle_cycles;

    // Receiver stall control
    bit          rx_hold_req;
    int          rx_hold_left;
    int          rx_mode;
    int          rx_epoch;
    int unsigned rx_phase;
    logic [7:0]  rx_mask;

    function automatic int unsigned eff_size(input logic [10:0] v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Prefix (right-aligned), prefix length, code length and delta of each kind
    function automatic void code_info(input code_kind_e k, output logic [7:0] pfx,
                                      output int plen, output int clen, output int delta);
        case (k)
            CK_ZERO:    begin pfx = 8'b0;      plen = 1; clen = 1; delta = 0;   end
            CK_PLUS4:   begin pfx = 8'b100;    plen = 3; clen = 3; delta = 4;   end
            CK_MINUS4:  begin pfx = 8'b101;    plen = 3; clen = 3; delta = -4;  end
            CK_PLUS11:  begin pfx = 8'b1101;   plen = 4; clen = 4; delta = 11;  end
            CK_MINUS11: begin pfx = 8'b1111;   plen = 4; clen = 4; delta = -11; end
            CK_PLUS20:  begin pfx = 8'b11001;  plen = 5; clen = 5; delta = 20;  end
            CK_MINUS20: begin pfx = 8'b110000; plen = 6; clen = 6; delta = -20; end
            CK_UNKNOWN: begin pfx = 8'b110001; plen = 6; clen = 8; delta = 0;   end
            default:    begin pfx = 8'b1110;   plen = 4; clen = 8; delta = 0;   end
        endcase
    endfunction

    // Decode one byte into decoded_px; returns 1 unless the byte is ignored
    function automatic bit decode_byte(input logic [7:0] d, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int          len;
        int          delta;
        int          v;
        int          plen;
        int          clen;
        int          kd;
        logic [7:0]  win;
        logic [7:0]  pfx;
        bit          absolute;
        bit          found;
        bit          fend;
        pix_t        t;
        decoded_px = {};
        w = eff_size(reg_width, 4, LINE_DEPTH);
        h = eff_size(reg_height, 2, 1024);
        if (fs) begin
            dec_active = 1'b1;
            dec_resv   = 0;
            dec_nbits  = 0;
            dec_row    = 0;
            dec_col    = 0;
        end
        if (!dec_active) return 1'b0;
        dec_resv  = ((dec_resv << 8) | d) & 32'h7FFF;
        dec_nbits = (dec_nbits + 8 > 15) ? 15 : dec_nbits + 8;
        while (dec_active && decoded_px.size() < 8) begin
            win  = (dec_nbits >= 8) ? 8'(dec_resv >> (dec_nbits - 8))
                                    : 8'(dec_resv << (8 - dec_nbits));
            slot = (dec_row % 2) * LINE_DEPTH
                 + ((dec_col < LINE_DEPTH) ? dec_col : LINE_DEPTH - 1);
            fend = 1'b0;
            if (dec_row < 2 && dec_col < 2) begin
                // raw pixel at the head of the first two rows
                if (dec_nbits < 8) break;
                v = win;
                dec_nbits -= 8;
            end else begin
                found    = 1'b0;
                absolute = 1'b0;
                len      = 8;
                delta    = 0;
                for (int k = 0; k < NUM_KINDS; k++) begin
                    code_info(code_kind_e'(k), pfx, plen, clen, kd);
                    if (!found && (win >> (8 - plen)) == pfx) begin
                        found    = 1'b1;
                        len      = clen;
                        delta    = kd;
                        absolute = (code_kind_e'(k) == CK_ABS);
                    end
                end
                if (len > dec_nbits) break;
                dec_nbits -= len;
                if (absolute) v = {win[3:0], 4'b0000};
                else if (dec_col < 2) v = delta + int'(dec_line[slot]);
                else if (dec_row < 2) v = delta + int'(dec_hist1);
                else v = delta + (int'(dec_line[slot]) + int'(dec_hist1)) / 2;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            dec_resv &= (32'd1 << dec_nbits) - 1;

            dec_line[slot] = v[7:0];
            dec_hist1      = dec_hist0;
            dec_hist0      = v[7:0];

            // advance position, close the frame after its last pixel
            dec_col++;
            if (dec_col >= w) begin
                dec_col = 0;
                dec_row++;
                if (dec_row >= h) begin
                    fend       = 1'b1;
                    dec_row    = 0;
                    dec_active = 1'b0;
                    dec_resv   = 0;
                    dec_nbits  = 0;
                end
            end
            t.pixel       = v[7:0];
            t.frame_end   = fend;
            t.last_of_run = 1'b0;
            decoded_px.push_back(t);
        end
        if (decoded_px.size() > 0) begin
            t = decoded_px.pop_back();
            t.last_of_run = 1'b1;
            decoded_px.push_back(t);
        end
        return 1'b1;
    endfunction

    // Next byte of a stream of random prefix codes
    function automatic logic [7:0] coded_byte();
        logic [7:0] pfx;
        logic [7:0] b;
        int         plen;
        int         clen;
        int         delta;
        while (gen_bits.size() < 8) begin
            code_info(code_kind_e'($urandom_range(0, NUM_KINDS - 1)), pfx, plen, clen, delta);
            for (int i = plen - 1; i >= 0; i--) gen_bits.push_back(pfx[i]);
            for (int i = plen; i < clen; i++) gen_bits.push_back($urandom_range(0, 1));
        end
        b = 8'h00;
        for (int i = 0; i < 8; i++) b = {b[6:0], gen_bits.pop_front()};
        return b;
    endfunction

    function automatic logic [7:0] next_byte(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 8'h00;
        if (r < zero_pct + 20) return 8'($urandom);
        return coded_byte();
    endfunction

    function automatic void add_cfg(input logic idx, input logic [10:0] val);
        stim_row_t r;
        r = '0;
        r.op    = ROW_CFG;
        r.idx   = idx;
        r.value = val;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic fs,
                                     input logic typed);
        stim_row_t r;
        r = '0;
        r.op        = ROW_BYTE;
        r.data      = d;
        r.fs        = fs;
        r.typed     = typed;
        r.exp_pixel = d;
        dir_rows.push_back(r);
    endfunction

    // Offer one item; entered and left at a falling edge
    task automatic put_byte(input logic [7:0] d, input logic fs, input logic typed);
        pix_t t;
        if (tx_burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            tx_burst_left = $urandom_range(1, 24);
        end
        tx_burst_left--;
        i_in_valid    <= 1'b1;
        i_data_byte   <= d;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (decode_byte(d, fs)) n_items++;
        if (typed) begin
            // raw pixel read straight off the byte
            t.pixel       = d;
            t.frame_end   = 1'b0;
            t.last_of_run = 1'b1;
            pixel_q.push_back(t);
        end else begin
            foreach (decoded_px[i]) pixel_q.push_back(decoded_px[i]);
        end
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every owed pixel, then let the block settle
    task automatic wait_all_pixels();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [10:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == C_REG_FRAME_WIDTH) reg_width = val;
        else reg_height = val;
        @(negedge i_clk);
    endtask

    // One frame: start byte, then codes until the frame closes or the cap is hit
    task automatic send_frame(input int max_bytes, input int zero_pct, input bit allow_shrink);
        int sent;
        bit shrunk;
        shrunk = 1'b0;
        put_byte(8'($urandom), 1'b1, 1'b0);
        sent = 1;
        while (dec_active && sent < max_bytes) begin
            // size shrink in the middle of a frame
            if (allow_shrink && !shrunk && $urandom_range(0, 39) == 0) begin
                wait_all_pixels();
                if ($urandom_range(0, 1) == 1)
                    write_reg(C_REG_FRAME_WIDTH,
                              11'($urandom_range(4, eff_size(reg_width, 4, LINE_DEPTH))));
                else
                    write_reg(C_REG_FRAME_HEIGHT,
                              11'($urandom_range(2, eff_size(reg_height, 2, 1024))));
                shrunk = 1'b1;
            end
            // occasional restart in the middle of a frame
            if ($urandom_range(0, 49) == 0) put_byte(8'($urandom), 1'b1, 1'b0);
            else put_byte(next_byte(zero_pct), 1'b0, 1'b0);
            sent++;
        end
    endtask

    // Pixel checker
    always @(posedge i_clk) begin
        pix_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_ERR_PRINT)
                    $error("unexpected pixel %0d with nothing owed", o_pixel);
            end else begin
                e = pixel_q.pop_front();
                if (o_pixel !== e.pixel) begin
                    err_count++;
                    if (err_count <= MAX_ERR_PRINT)
                        $error("pixel: expected %0d, got %0d", e.pixel, o_pixel);
                end
                if (o_frame_end !== e.frame_end) begin
                    err_count++;
                    if (err_count <= MAX_ERR_PRINT)
                        $error("frame_end: expected %0d, got %0d", e.frame_end, o_frame_end);
                end
                if (o_last_of_run !== e.last_of_run) begin
                    err_count++;
                    if (err_count <= MAX_ERR_PRINT)
                        $error("last_of_run: expected %0d, got %0d",
                               e.last_of_run, o_last_of_run);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver stall patterns, with a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_epoch == 0) begin
                rx_mode  = $urandom_range(0, 3);
                rx_mask  = 8'($urandom);
                rx_epoch = $urandom_range(16, 96);
            end
            rx_epoch--;
            rx_phase++;
            case (rx_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= !rx_mask[rx_phase % 8];
                default: i_out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Main sequence
    initial begin
        int n_saved;
        int phase;
        bit wide_done;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = C_REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_frame_start = 1'b0;
        i_out_ready   = 1'b0;
        err_count     = 0;
        n_items       = 0;
        tx_burst_left = 0;
        idle_cycles   = 0;
        rx_hold_req   = 1'b0;
        rx_hold_left  = 0;
        rx_epoch      = 0;
        rx_phase      = 0;
        reg_width     = C_RESET_WIDTH;
        reg_height    = C_RESET_HEIGHT;
        dec_resv      = 0;
        dec_nbits     = 0;
        dec_row       = 0;
        dec_col       = 0;
        dec_hist0     = '0;
        dec_hist1     = '0;
        dec_active    = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: sizes below the minimum, raw extremes, codes, a high clamp
        add_cfg(C_REG_FRAME_WIDTH, 11'd0);
        add_cfg(C_REG_FRAME_HEIGHT, 11'd0);
        add_byte(8'hFF, 1'b1, 1'b1);
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'hC0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hEF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);   // ignored while no frame is open
        add_cfg(C_REG_FRAME_HEIGHT, 11'd4);
        add_byte(8'h10, 1'b1, 1'b1);
        add_byte(8'hF0, 1'b0, 1'b1);
        add_byte(8'hD0, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b0, 1'b0);
        add_byte(8'hC8, 1'b0, 1'b0);
        add_byte(8'hC0, 1'b0, 1'b0);
        add_byte(8'hC4, 1'b0, 1'b0);
        add_byte(8'hA0, 1'b0, 1'b0);
        add_byte(8'hE3, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b1);   // frame start after the frame has closed
        add_byte(8'h00, 1'b0, 1'b0);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                wait_all_pixels();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                put_byte(dir_rows[i].data, dir_rows[i].fs, dir_rows[i].typed);
            end
        end

        // Random phases of frames with random sizes
        n_items   = 0;
        phase     = 0;
        wide_done = 1'b0;
        while (n_items < RANDOM_ITEMS || !wide_done) begin
            wait_all_pixels();
            if (phase == 1) begin
                // long receiver hold while a tall frame keeps coming
                write_reg(C_REG_FRAME_WIDTH, 11'd8);
                write_reg(C_REG_FRAME_HEIGHT, 11'h7FF);
                rx_hold_req = 1'b1;
                send_frame(60, 70, 1'b0);
            end else if (!wide_done && n_items >= 80) begin
                // widest row, clamped from the top of the register range
                n_saved = n_items;
                write_reg(C_REG_FRAME_WIDTH, 11'h7FF);
                write_reg(C_REG_FRAME_HEIGHT, 11'd1);
                send_frame(400, 92, 1'b0);
                n_items   = n_saved;
                wide_done = 1'b1;
            end else begin
                if (phase == 0 || $urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       write_reg(C_REG_FRAME_WIDTH, 11'($urandom_range(0, 3)));
                        default: write_reg(C_REG_FRAME_WIDTH, 11'($urandom_range(4, 12)));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       write_reg(C_REG_FRAME_HEIGHT, 11'($urandom_range(0, 1)));
                        1:       write_reg(C_REG_FRAME_HEIGHT, 11'h7FF);
                        default: write_reg(C_REG_FRAME_HEIGHT, 11'($urandom_range(2, 6)));
                    endcase
                end
                repeat ($urandom_range(1, 3)) begin
                    // stray bytes between frames
                    if (!dec_active && $urandom_range(0, 2) == 0)
                        repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0, 1'b0);
                    send_frame(48, 30, 1'b1);
                end
            end
            phase++;
        end

        wait_all_pixels();
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bdv_pkg.sv
rtl/bdv_ctrl.sv
rtl/bdv_datapath.sv
rtl/bayer_dpcm_vlc_decoder.sv
tb/sv/bayer_dpcm_vlc_decoder_tb.sv
